[rtl/quic_transport_param_parser_macros.svh]
// Assertion macros for the transport parameter parser.
// Included by the top level; no other dependencies.
`ifndef QUIC_TRANSPORT_PARAM_PARSER_MACROS_SVH
`define QUIC_TRANSPORT_PARAM_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define QTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define QTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QTP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define QTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/quic_tp_pkg.sv]
// Types, constants and id classification helpers for the transport parameter parser.
// No dependencies.
`default_nettype none
package quic_tp_pkg;
    localparam int MAX_CID_BYTES      = 20;
    localparam int RESET_TOKEN_BYTES  = 16;
    localparam int MIN_DATAGRAM_BYTES = 1200;
    localparam int PREF_FIXED         = 4 + 2 + 16 + 2 + 1 + RESET_TOKEN_BYTES;
    localparam int FIFO_DEPTH         = 4;

    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_FLAG = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_SRV_ONLY  = 3'd3;
    localparam logic [2:0] ST_FORMAT    = 3'd4;
    localparam logic [2:0] ST_LIMIT     = 3'd5;
    localparam logic [2:0] ST_FINAL     = 3'd6;

    localparam logic [2:0] REG_OWNER    = 3'd0;
    localparam logic [2:0] REG_UDP      = 3'd1;
    localparam logic [2:0] REG_ACK_EXP  = 3'd2;
    localparam logic [2:0] REG_ACK_DLY  = 3'd3;
    localparam logic [2:0] REG_CID_LIM  = 3'd4;

    localparam logic [4:0] ID_STREAMS_BIDI = 5'd8;
    localparam logic [4:0] ID_STREAMS_UNI  = 5'd9;
    localparam logic [4:0] ID_UDP          = 5'd3;
    localparam logic [4:0] ID_ACK_EXP      = 5'd10;
    localparam logic [4:0] ID_ACK_DLY      = 5'd11;
    localparam logic [4:0] ID_FLAG         = 5'd12;
    localparam logic [4:0] ID_PREF_ADDR    = 5'd13;
    localparam logic [4:0] ID_CID_LIM      = 5'd14;
    localparam logic [4:0] ID_TOKEN        = 5'd2;
    localparam logic [4:0] ID_MAX_KNOWN    = 5'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  param_id;
        logic [61:0] param_value;
        logic [5:0]  byte_offset;
        logic [2:0]  status;
        logic        last;
    } t_result;

    function automatic logic is_integer_id(input logic [4:0] id);
        is_integer_id = (id == 5'd1) || (id >= 5'd3 && id <= 5'd11) || (id == 5'd14);
    endfunction

    function automatic logic is_cid_id(input logic [4:0] id);
        is_cid_id = (id == 5'd0) || (id == 5'd15) || (id == 5'd16);
    endfunction

    function automatic logic is_server_only(input logic [4:0] id);
        is_server_only = (id == 5'd0) || (id == 5'd2) || (id == 5'd13) || (id == 5'd16);
    endfunction
endpackage
`default_nettype wire

[rtl/quic_transport_param_parser.sv]
// Byte-serial parser of a transport parameter block with a small result queue.
// Depends on quic_tp_pkg and quic_transport_param_parser_macros.svh.
`default_nettype none
`include "quic_transport_param_parser_macros.svh"
// The parser takes one byte of a transport parameter block per cycle and
// emits at most two result transactions per byte: one parameter report and,
// on the last byte, the end status. The whole decode of a byte is a single
// pass of combinational logic from the parse state registers to a four-entry
// result queue, so a byte transaction is accepted every cycle as long as the
// queue has room for two results; the queue drains one result per cycle, and
// a stalled output only blocks input once three or more results are waiting.
// The results of an accepted byte are registered straight into the queue.
// The user must write the default-value registers through the APB port only
// while no block bytes are in flight; the block itself does not enforce this.
// A write updates the held value of a parameter not yet seen in this block.
module quic_transport_param_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_block,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [4:0]       o_param_id,
    output logic [61:0]      o_param_value,
    output logic [5:0]       o_byte_offset,
    output logic [2:0]       o_status,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import quic_tp_pkg::*;

    typedef enum logic [2:0] {
        PH_ID0, PH_ID1, PH_LEN0, PH_LEN1, PH_VAL, PH_ERR
    } t_phase;

    // Parse state.
    t_phase      r_phase, n_phase;
    logic [61:0] r_acc, n_acc;
    logic [2:0]  r_vleft, n_vleft;
    logic [4:0]  r_id, n_id;
    logic        r_known, n_known;
    logic [61:0] r_bleft, n_bleft;
    logic [5:0]  r_off, n_off;
    logic [61:0] r_len, n_len;
    logic [16:0] r_seen, n_seen;
    logic [2:0]  r_err, n_err;
    logic [61:0] r_held_udp, n_held_udp;
    logic [61:0] r_held_exp, n_held_exp;
    logic [61:0] r_held_dly, n_held_dly;
    logic [61:0] r_held_cid, n_held_cid;

    // Configuration registers.
    logic        r_owner, n_owner;
    logic [15:0] r_def_udp, n_def_udp;
    logic [7:0]  r_def_exp, n_def_exp;
    logic [15:0] r_def_dly, n_def_dly;
    logic [7:0]  r_def_cid, n_def_cid;

    // Result queue.
    t_result     r_fifo [FIFO_DEPTH];
    logic [1:0]  r_head, n_head;
    logic [1:0]  r_tail, n_tail;
    logic [2:0]  r_count, n_count;

    logic        in_acc, out_acc, cfg_wr;
    t_result     res0, res1;
    logic        res0_v, res1_v;
    logic [2:0]  end_status;
    logic [61:0] acc_first, acc_more, need;
    logic [2:0]  left_first, left_more;
    logic        id_fire, len_fire, int_fire;
    logic        final_bad;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_ready = (r_count <= 3'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != 3'd0);

    assign o_kind        = r_fifo[r_head].kind;
    assign o_param_id    = r_fifo[r_head].param_id;
    assign o_param_value = r_fifo[r_head].param_value;
    assign o_byte_offset = r_fifo[r_head].byte_offset;
    assign o_status      = r_fifo[r_head].status;
    assign o_last        = r_fifo[r_head].last;

    always_comb begin
        case (paddr[4:2])
            REG_OWNER:   prdata = {31'd0, r_owner};
            REG_UDP:     prdata = {16'd0, r_def_udp};
            REG_ACK_EXP: prdata = {24'd0, r_def_exp};
            REG_ACK_DLY: prdata = {16'd0, r_def_dly};
            REG_CID_LIM: prdata = {24'd0, r_def_cid};
            default:     prdata = 32'd0;
        endcase
    end

    // Varint helpers: start from a first byte, or shift in a following byte.
    assign acc_first  = {56'd0, i_data_byte[5:0]};
    assign left_first = 3'((4'd1 << i_data_byte[7:6]) - 4'd1);
    assign acc_more   = {r_acc[53:0], i_data_byte};
    assign left_more  = r_vleft - 3'd1;
    assign need       = {58'd0, 4'(4'd1 << i_data_byte[7:6])};

    always_comb begin
        n_phase = r_phase;  n_acc = r_acc;  n_vleft = r_vleft;  n_id = r_id;
        n_known = r_known;  n_bleft = r_bleft;  n_off = r_off;  n_len = r_len;
        n_seen = r_seen;  n_err = r_err;
        n_held_udp = r_held_udp;  n_held_exp = r_held_exp;
        n_held_dly = r_held_dly;  n_held_cid = r_held_cid;
        n_owner = r_owner;  n_def_udp = r_def_udp;  n_def_exp = r_def_exp;
        n_def_dly = r_def_dly;  n_def_cid = r_def_cid;
        res0 = '0;  res0_v = 1'b0;  res1 = '0;  res1_v = 1'b0;
        id_fire = 1'b0;  len_fire = 1'b0;  int_fire = 1'b0;
        end_status = ST_OK;  final_bad = 1'b0;

        if (in_acc && i_byte_present) begin
            case (r_phase)
                PH_ID0, PH_LEN0: begin
                    n_acc   = acc_first;
                    n_vleft = left_first;
                    if (left_first == 3'd0) begin
                        id_fire  = (r_phase == PH_ID0);
                        len_fire = (r_phase == PH_LEN0);
                    end else begin
                        n_phase = (r_phase == PH_ID0) ? PH_ID1 : PH_LEN1;
                    end
                end
                PH_ID1, PH_LEN1: begin
                    n_acc   = acc_more;
                    n_vleft = left_more;
                    if (left_more == 3'd0) begin
                        id_fire  = (r_phase == PH_ID1);
                        len_fire = (r_phase == PH_LEN1);
                    end
                end
                PH_VAL: begin
                    n_off   = r_off + 6'd1;
                    n_bleft = r_bleft - 62'd1;
                    if (!r_known) begin
                        if (n_bleft == 62'd0) n_phase = PH_ID0;
                    end else if (is_integer_id(r_id)) begin
                        if (r_off == 6'd0) begin
                            if (need > r_len) begin
                                n_err = ST_TRUNC;  n_phase = PH_ERR;
                            end else if (need < r_len) begin
                                n_err = ST_FORMAT; n_phase = PH_ERR;
                            end else begin
                                n_acc    = acc_first;
                                n_vleft  = left_first;
                                int_fire = (left_first == 3'd0);
                            end
                        end else begin
                            n_acc    = acc_more;
                            n_vleft  = left_more;
                            int_fire = (left_more == 3'd0);
                        end
                    end else if (r_id == ID_PREF_ADDR && r_off == 6'd24 &&
                                 (i_data_byte == 8'd0 ||
                                  i_data_byte > 8'(MAX_CID_BYTES) ||
                                  r_len != 62'(PREF_FIXED) + {54'd0, i_data_byte})) begin
                        n_err = ST_FORMAT; n_phase = PH_ERR;
                    end else begin
                        res0_v = 1'b1;
                        res0.kind        = KIND_BYTE;
                        res0.param_id    = r_id;
                        res0.param_value = {54'd0, i_data_byte};
                        res0.byte_offset = r_off;
                        if (n_bleft == 62'd0) n_phase = PH_ID0;
                    end
                end
                default: begin
                end
            endcase
        end

        // Identifier complete: only ids up to sixteen are tracked.
        if (id_fire) begin
            n_known = (n_acc <= {57'd0, ID_MAX_KNOWN});
            n_id    = n_known ? n_acc[4:0] : 5'd0;
            n_phase = PH_LEN0;
        end

        // Length complete: duplicate, role and length checks, and the flag report.
        if (len_fire) begin
            n_len   = n_acc;
            n_bleft = n_acc;
            n_off   = 6'd0;
            n_phase = (n_acc == 62'd0) ? PH_ID0 : PH_VAL;
            if (r_known) begin
                if (r_seen[r_id]) begin
                    n_err = ST_DUP; n_phase = PH_ERR;
                end else begin
                    n_seen[r_id] = 1'b1;
                    if (!r_owner && is_server_only(r_id)) begin
                        n_err = ST_SRV_ONLY; n_phase = PH_ERR;
                    end else if (r_id == ID_FLAG) begin
                        if (n_acc != 62'd0) begin
                            n_err = ST_FORMAT; n_phase = PH_ERR;
                        end else begin
                            res0_v = 1'b1;
                            res0.kind        = KIND_FLAG;
                            res0.param_id    = r_id;
                            res0.param_value = 62'd1;
                        end
                    end else if (is_integer_id(r_id)) begin
                        if (n_acc == 62'd0) begin
                            n_err = ST_TRUNC; n_phase = PH_ERR;
                        end
                    end else if (is_cid_id(r_id)) begin
                        if (n_acc > 62'(MAX_CID_BYTES)) begin
                            n_err = ST_FORMAT; n_phase = PH_ERR;
                        end
                    end else if (r_id == ID_TOKEN) begin
                        if (n_acc != 62'(RESET_TOKEN_BYTES)) begin
                            n_err = ST_FORMAT; n_phase = PH_ERR;
                        end
                    end else if (n_acc < 62'(PREF_FIXED)) begin
                        n_err = ST_FORMAT; n_phase = PH_ERR;
                    end
                end
            end
        end

        // Integer value complete: stream limit check, held value update and report.
        if (int_fire) begin
            if ((r_id == ID_STREAMS_BIDI || r_id == ID_STREAMS_UNI) &&
                n_acc > (62'd1 << 60)) begin
                n_err = ST_LIMIT; n_phase = PH_ERR;
            end else begin
                if (r_id == ID_UDP)     n_held_udp = n_acc;
                if (r_id == ID_ACK_EXP) n_held_exp = n_acc;
                if (r_id == ID_ACK_DLY) n_held_dly = n_acc;
                if (r_id == ID_CID_LIM) n_held_cid = n_acc;
                n_phase = PH_ID0;
                res0_v = 1'b1;
                res0.kind        = KIND_INT;
                res0.param_id    = r_id;
                res0.param_value = n_acc;
            end
        end

        // End of block: report status, then return to the empty block state.
        if (in_acc && i_end_of_block) begin
            final_bad = (n_held_udp < 62'(MIN_DATAGRAM_BYTES)) ||
                        (n_held_udp > 62'd65527) || (n_held_exp > 62'd20) ||
                        (n_held_dly >= (62'd1 << 14)) || (n_held_cid < 62'd2);
            if (n_phase == PH_ERR)      end_status = n_err;
            else if (n_phase != PH_ID0) end_status = ST_TRUNC;
            else if (final_bad)         end_status = ST_FINAL;
            else                        end_status = ST_OK;
            res1_v = 1'b1;
            res1.kind   = KIND_END;
            res1.status = end_status;
            res1.last   = 1'b1;
            n_phase = PH_ID0;  n_acc = '0;  n_vleft = '0;  n_id = '0;
            n_known = 1'b0;  n_bleft = '0;  n_len = '0;  n_off = '0;
            n_seen = '0;  n_err = ST_OK;
            n_held_udp = {46'd0, r_def_udp};
            n_held_exp = {54'd0, r_def_exp};
            n_held_dly = {46'd0, r_def_dly};
            n_held_cid = {54'd0, r_def_cid};
        end

        if (cfg_wr) begin
            case (paddr[4:2])
                REG_OWNER: n_owner = pwdata[0];
                REG_UDP: begin
                    n_def_udp = pwdata[15:0];
                    if (!n_seen[ID_UDP]) n_held_udp = {46'd0, pwdata[15:0]};
                end
                REG_ACK_EXP: begin
                    n_def_exp = pwdata[7:0];
                    if (!n_seen[ID_ACK_EXP]) n_held_exp = {54'd0, pwdata[7:0]};
                end
                REG_ACK_DLY: begin
                    n_def_dly = pwdata[15:0];
                    if (!n_seen[ID_ACK_DLY]) n_held_dly = {46'd0, pwdata[15:0]};
                end
                REG_CID_LIM: begin
                    n_def_cid = pwdata[7:0];
                    if (!n_seen[ID_CID_LIM]) n_held_cid = {54'd0, pwdata[7:0]};
                end
                default: begin
                end
            endcase
        end

        n_head  = out_acc ? r_head + 2'd1 : r_head;
        n_tail  = r_tail + 2'(res0_v) + 2'(res1_v);
        n_count = r_count + 3'(res0_v) + 3'(res1_v) - 3'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ID0;  r_acc <= '0;  r_vleft <= '0;  r_id <= '0;
            r_known <= 1'b0;  r_bleft <= '0;  r_off <= '0;  r_len <= '0;
            r_seen <= '0;  r_err <= ST_OK;
            r_held_udp <= 62'd65527;  r_held_exp <= 62'd3;
            r_held_dly <= 62'd25;  r_held_cid <= 62'd2;
            r_owner <= 1'b0;  r_def_udp <= 16'd65527;  r_def_exp <= 8'd3;
            r_def_dly <= 16'd25;  r_def_cid <= 8'd2;
            r_head <= '0;  r_tail <= '0;  r_count <= '0;
        end else begin
            r_phase <= n_phase;  r_acc <= n_acc;  r_vleft <= n_vleft;  r_id <= n_id;
            r_known <= n_known;  r_bleft <= n_bleft;  r_off <= n_off;  r_len <= n_len;
            r_seen <= n_seen;  r_err <= n_err;
            r_held_udp <= n_held_udp;  r_held_exp <= n_held_exp;
            r_held_dly <= n_held_dly;  r_held_cid <= n_held_cid;
            r_owner <= n_owner;  r_def_udp <= n_def_udp;  r_def_exp <= n_def_exp;
            r_def_dly <= n_def_dly;  r_def_cid <= n_def_cid;
            r_head <= n_head;  r_tail <= n_tail;  r_count <= n_count;
        end
        // Queue entries carry payload only and need no reset.
        if (res0_v) r_fifo[r_tail] <= res0;
        if (res1_v) r_fifo[r_tail + 2'(res0_v)] <= res1;
    end

    `QTP_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= 3'(FIFO_DEPTH))
    `QTP_ASSERT_NOW(a_last_is_end, i_clk, i_rst_n, o_valid && o_last, o_kind == KIND_END)
    `QTP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, in_acc && i_end_of_block, r_phase == PH_ID0 && r_seen == '0)
endmodule
`default_nettype wire
